### rtl/core/fdsd_pkg.sv
`timescale 1ns / 1ps

package fdsd_pkg;

    localparam int DIGIT_COUNT_DEF = 4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [7:0] DATA_CMD_BYTE = 8'h40;
    localparam logic [7:0] ADDR_CMD_BYTE = 8'hC0;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // n / 10 == (n * 52429) >> 19 for every 16-bit n
    localparam logic [31:0] DIV10_MAGIC = 32'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [14:0] {
        PH_IDLE = 15'b000000000000001,
        PH_S1   = 15'b000000000000010,
        PH_S2   = 15'b000000000000100,
        PH_S3   = 15'b000000000001000,
        PH_WD   = 15'b000000000010000,
        PH_WH   = 15'b000000000100000,
        PH_WL   = 15'b000000001000000,
        PH_AZ   = 15'b000000010000000,
        PH_AR   = 15'b000000100000000,
        PH_AH   = 15'b000001000000000,
        PH_AL   = 15'b000010000000000,
        PH_P1   = 15'b000100000000000,
        PH_P2   = 15'b001000000000000,
        PH_P3   = 15'b010000000000000,
        PH_P4   = 15'b100000000000000
    } phase_t;

    typedef struct packed {
        logic done_res;
        logic busy_res;
        logic dio_released;
        logic dio_level;
        logic clk_level;
    } result_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h67;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/four_digit_segment_serial_driver_core.sv
`timescale 1ns / 1ps

// Channel  | Dir | Signals                     | Contents
// ---------+-----+-----------------------------+-----------------------------------
// s_axis   | in  | tvalid tready tdata tuser   | tuser command, tdata number/bright
// m_axis   | out | tvalid tready tdata tlast   | tdata pin levels/busy, tlast done
//
// One input transfer per cycle while the output buffer has room, one result
// transfer per input through the result register; a two-entry output buffer keeps
// input flowing while a result waits. The decimal split starts on a load and runs
// behind the pin sequence, one place per cycle through one multiplier.
// Reset puts the pins at clock high, data high, driven, and the sequencer idle.

module four_digit_segment_serial_driver_core #(
    parameter int DIGIT_COUNT = fdsd_pkg::DIGIT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] number, [23:16] brightness
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] clk_level, [1] dio_level,
                                        // [2] dio_released, [3] busy_res, [7:4] 0
    output logic        m_axis_tlast    // done_res
);
    import fdsd_pkg::*;

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [3:0] LAST_FRAME = 4'(DIGIT_COUNT + 2);
    localparam logic [3:0] LAST_SEG_FRAME = 4'(DIGIT_COUNT + 1);

    phase_t     phase_reg,      phase_next;
    logic [3:0] frame_reg,      frame_next;
    logic [3:0] bit_cnt_reg,    bit_cnt_next;
    logic [7:0] shift_reg,      shift_next;
    logic [7:0] bright_reg,     bright_next;
    logic       clk_lvl_reg,    clk_lvl_next;
    logic       dio_lvl_reg,    dio_lvl_next;
    logic       rel_reg,        rel_next;

    logic             in_acc;
    logic             digit_start;
    logic             done;
    logic [3:0]       frame_sel;
    logic [IDX_W-1:0] seg_idx;
    logic [7:0]       seg_data;
    logic [7:0]       frame_byte;
    logic [3:0]       bit_cnt_inc;
    result_t          res;
    result_t          out_res;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // byte that the next frame shifts out
    assign frame_sel = (phase_reg == PH_AL) ? frame_reg + 4'd1 : frame_reg;
    assign seg_idx   = IDX_W'(frame_sel - 4'd2);

    always_comb
    begin
        if (frame_sel == 4'd0)
        begin
            frame_byte = DATA_CMD_BYTE;
        end
        else if (frame_sel == 4'd1)
        begin
            frame_byte = ADDR_CMD_BYTE;
        end
        else if (frame_sel <= LAST_SEG_FRAME)
        begin
            frame_byte = seg_data;
        end
        else if (frame_sel == LAST_FRAME)
        begin
            frame_byte = bright_reg;
        end
        else
        begin
            frame_byte = 8'h00;
        end
    end

    assign bit_cnt_inc = bit_cnt_reg + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        frame_next   = frame_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        bright_next  = bright_reg;
        clk_lvl_next = clk_lvl_reg;
        dio_lvl_next = dio_lvl_reg;
        rel_next     = rel_reg;
        digit_start  = 1'b0;
        done         = 1'b0;

        if (in_acc)
        begin
            if (s_axis_tuser == CMD_LOAD)
            begin
                // drop loads while a sequence is running
                if (phase_reg == PH_IDLE)
                begin
                    digit_start  = 1'b1;
                    bright_next  = s_axis_tdata[23:16];
                    frame_next   = 4'd0;
                    bit_cnt_next = 4'd0;
                    phase_next   = PH_S1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_S1:
                    begin
                        clk_lvl_next = 1'b1;
                        phase_next   = PH_S2;
                    end
                    PH_S2:
                    begin
                        dio_lvl_next = 1'b1;
                        phase_next   = PH_S3;
                    end
                    PH_S3:
                    begin
                        dio_lvl_next = 1'b0;
                        shift_next   = frame_byte;
                        bit_cnt_next = 4'd0;
                        phase_next   = PH_WD;
                    end
                    PH_WD:
                    begin
                        clk_lvl_next = 1'b0;
                        rel_next     = 1'b0;
                        dio_lvl_next = shift_reg[0];
                        phase_next   = PH_WH;
                    end
                    PH_WH:
                    begin
                        clk_lvl_next = 1'b1;
                        phase_next   = PH_WL;
                    end
                    PH_WL:
                    begin
                        clk_lvl_next = 1'b0;
                        shift_next   = shift_reg >> 1;
                        bit_cnt_next = bit_cnt_inc;
                        phase_next   = (bit_cnt_inc >= BITS_PER_BYTE) ? PH_AZ : PH_WD;
                    end
                    PH_AZ:
                    begin
                        dio_lvl_next = 1'b0;
                        phase_next   = PH_AR;
                    end
                    PH_AR:
                    begin
                        rel_next   = 1'b1;
                        phase_next = PH_AH;
                    end
                    PH_AH:
                    begin
                        clk_lvl_next = 1'b1;
                        phase_next   = PH_AL;
                    end
                    PH_AL:
                    begin
                        clk_lvl_next = 1'b0;
                        // address byte and segment bytes run back to back in one frame
                        if (frame_reg >= 4'd1 && frame_reg <= 4'(DIGIT_COUNT))
                        begin
                            frame_next   = frame_sel;
                            shift_next   = frame_byte;
                            bit_cnt_next = 4'd0;
                            phase_next   = PH_WD;
                        end
                        else
                        begin
                            phase_next = PH_P1;
                        end
                    end
                    PH_P1:
                    begin
                        rel_next     = 1'b0;
                        clk_lvl_next = 1'b0;
                        phase_next   = PH_P2;
                    end
                    PH_P2:
                    begin
                        dio_lvl_next = 1'b0;
                        phase_next   = PH_P3;
                    end
                    PH_P3:
                    begin
                        clk_lvl_next = 1'b1;
                        phase_next   = PH_P4;
                    end
                    PH_P4:
                    begin
                        dio_lvl_next = 1'b1;
                        if (frame_reg >= LAST_FRAME)
                        begin
                            done       = 1'b1;
                            frame_next = 4'd0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            // stop's last step doubles as the next start's first
                            frame_next = frame_reg + 4'd1;
                            phase_next = PH_S2;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            frame_reg   <= 4'd0;
            bit_cnt_reg <= 4'd0;
            shift_reg   <= 8'h00;
            bright_reg  <= 8'h00;
            clk_lvl_reg <= 1'b1;
            dio_lvl_reg <= 1'b1;
            rel_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            frame_reg   <= frame_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            bright_reg  <= bright_next;
            clk_lvl_reg <= clk_lvl_next;
            dio_lvl_reg <= dio_lvl_next;
            rel_reg     <= rel_next;
        end
    end

    fdsd_digit_unit #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_digit (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (digit_start),
        .number  (s_axis_tdata[15:0]),
        .rd_idx  (seg_idx),
        .rd_data (seg_data)
    );

    assign res.clk_level    = clk_lvl_next;
    assign res.dio_level    = dio_lvl_next;
    assign res.dio_released = rel_next;
    assign res.busy_res     = (phase_next != PH_IDLE);
    assign res.done_res     = done;

    fdsd_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_acc),
        .push_data  (res),
        .push_ready (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_res)
    );

    assign m_axis_tdata = {4'b0000, out_res.busy_res, out_res.dio_released,
                           out_res.dio_level, out_res.clk_level};
    assign m_axis_tlast = out_res.done_res;

`ifndef ASSERT_OFF
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser == CMD_LOAD && phase_reg == PH_IDLE) |=> (phase_reg == PH_S1))
        else $error("load while idle did not start a sequence");

    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg <= LAST_FRAME)
        else $error("frame index past last frame");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= BITS_PER_BYTE)
        else $error("bit count past one byte");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (phase_reg == PH_IDLE && frame_reg == 4'd0))
        else $error("sequencer not idle after completion");
`endif

endmodule

### rtl/core/fdsd_digit_unit.sv
`timescale 1ns / 1ps

module fdsd_digit_unit #(
    parameter int DIGIT_COUNT = fdsd_pkg::DIGIT_COUNT_DEF,
    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      number,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_data
);
    import fdsd_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

    logic             active_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      work_reg;
    logic [7:0]       seg_reg [DIGIT_COUNT];

    logic [31:0] prod;
    logic [15:0] quot;
    logic [15:0] quot_x10;
    logic [3:0]  rem;

    // one decimal place per cycle, lowest place first
    assign prod     = {16'b0, work_reg} * DIV10_MAGIC;
    assign quot     = 16'(prod[31:DIV10_SHIFT]);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = 4'(work_reg - quot_x10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            idx_reg    <= LAST_IDX;
        end
        else if (active_reg)
        begin
            if (idx_reg == '0)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= number;
        end
        else if (active_reg)
        begin
            work_reg         <= quot;
            seg_reg[idx_reg] <= seg_code(rem);
        end
    end

    assign rd_data = seg_reg[rd_idx];

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (idx_reg <= LAST_IDX))
        else $error("digit index out of range");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && idx_reg == '0 && !start) |=> !active_reg)
        else $error("digit unit kept running after last place");
`endif

endmodule

### rtl/core/fdsd_out_buf.sv
`timescale 1ns / 1ps

module fdsd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fdsd_pkg::result_t push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output fdsd_pkg::result_t out_data
);
    import fdsd_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            // output slot frees up: drain the skid first
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output slot is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid did not move to output");
`endif

endmodule

### verif/segment_link_checker.sv
`timescale 1ns / 1ps

module segment_link_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] number, [23:16] brightness
    input  logic        s_axis_tuser,   // [0] command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [0] clk_level, [1] dio_level,
                                        // [2] dio_released, [3] busy_res, [7:4] 0
    input  logic        m_axis_tlast,   // done_res
    output int          fault_count,
    output int          pins_pending
);
    import fdsd_pkg::*;

    localparam int DIGITS     = DIGIT_COUNT_DEF;
    localparam int LAST_FRAME = DIGITS + 2;

    // seven-segment patterns for 9 down to 0, digit 0 in the lowest byte
    localparam logic [79:0] GLYPHS = {
        8'h67, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    phase_t      phase;
    logic [3:0]  frame;
    logic [3:0]  bits;
    logic [7:0]  shifter;
    logic [7:0]  bright;
    logic [7:0]  segs [DIGITS];
    logic        clk_pin;
    logic        dio_pin;
    logic        rel_pin;

    result_t     expected_pins [$];

    function automatic logic [7:0] frame_byte(input logic [3:0] f);
        if (f == 4'd0)
            return DATA_CMD_BYTE;
        if (f == 4'd1)
            return ADDR_CMD_BYTE;
        if (f >= 4'd2 && f < 2 + DIGITS)
            return segs[f - 4'd2];
        if (f == LAST_FRAME)
            return bright;
        return 8'h00;
    endfunction

    // Advance the pin sequencer by one transfer and return the pins it shows.
    function automatic result_t advance_link(input logic cmd, input logic [15:0] num,
                                             input logic [7:0] bri);
        result_t r;
        logic    fin;
        int      n;
        fin = 1'b0;
        if (cmd == CMD_LOAD)
        begin
            if (phase == PH_IDLE)
            begin
                n = num;
                for (int i = DIGITS - 1; i >= 0; i--)
                begin
                    segs[i] = GLYPHS[(n % 10) * 8 +: 8];
                    n = n / 10;
                end
                bright = bri;
                frame  = '0;
                bits   = '0;
                phase  = PH_S1;
            end
        end
        else
        begin
            case (phase)
                PH_S1:
                begin
                    clk_pin = 1'b1;
                    phase   = PH_S2;
                end
                PH_S2:
                begin
                    dio_pin = 1'b1;
                    phase   = PH_S3;
                end
                PH_S3:
                begin
                    dio_pin = 1'b0;
                    shifter = frame_byte(frame);
                    bits    = '0;
                    phase   = PH_WD;
                end
                PH_WD:
                begin
                    clk_pin = 1'b0;
                    rel_pin = 1'b0;
                    dio_pin = shifter[0];
                    phase   = PH_WH;
                end
                PH_WH:
                begin
                    clk_pin = 1'b1;
                    phase   = PH_WL;
                end
                PH_WL:
                begin
                    clk_pin = 1'b0;
                    shifter = shifter >> 1;
                    bits    = bits + 4'd1;
                    phase   = (bits >= BITS_PER_BYTE) ? PH_AZ : PH_WD;
                end
                PH_AZ:
                begin
                    dio_pin = 1'b0;
                    phase   = PH_AR;
                end
                PH_AR:
                begin
                    rel_pin = 1'b1;
                    phase   = PH_AH;
                end
                PH_AH:
                begin
                    clk_pin = 1'b1;
                    phase   = PH_AL;
                end
                PH_AL:
                begin
                    clk_pin = 1'b0;
                    // address and segment bytes run back to back without a stop
                    if (frame >= 4'd1 && frame <= DIGITS)
                    begin
                        frame   = frame + 4'd1;
                        shifter = frame_byte(frame);
                        bits    = '0;
                        phase   = PH_WD;
                    end
                    else
                    begin
                        phase = PH_P1;
                    end
                end
                PH_P1:
                begin
                    rel_pin = 1'b0;
                    clk_pin = 1'b0;
                    phase   = PH_P2;
                end
                PH_P2:
                begin
                    dio_pin = 1'b0;
                    phase   = PH_P3;
                end
                PH_P3:
                begin
                    clk_pin = 1'b1;
                    phase   = PH_P4;
                end
                PH_P4:
                begin
                    dio_pin = 1'b1;
                    if (frame >= LAST_FRAME)
                    begin
                        fin   = 1'b1;
                        frame = '0;
                        phase = PH_IDLE;
                    end
                    else
                    begin
                        // stop's last step doubles as the next start's clock-high step
                        frame = frame + 4'd1;
                        phase = PH_S2;
                    end
                end
                default: phase = PH_IDLE;
            endcase
        end
        r.clk_level    = clk_pin;
        r.dio_level    = dio_pin;
        r.dio_released = rel_pin;
        r.busy_res     = (phase != PH_IDLE);
        r.done_res     = fin;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [3:0] want,
                                 input logic [3:0] got);
        if (want !== got)
        begin
            fault_count++;
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            phase   = PH_IDLE;
            frame   = '0;
            bits    = '0;
            shifter = '0;
            bright  = '0;
            for (int i = 0; i < DIGITS; i++)
                segs[i] = '0;
            clk_pin = 1'b1;
            dio_pin = 1'b1;
            rel_pin = 1'b0;
            expected_pins.delete();
            fault_count  = 0;
            pins_pending = 0;
        end
        else
        begin
            // retire the result first: it can never belong to this edge's input
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pins.size() == 0)
                begin
                    fault_count++;
                    $error("result transfer with no input waiting for it");
                end
                else
                begin
                    want = expected_pins.pop_front();
                    compare_field("clk_level", want.clk_level, m_axis_tdata[0]);
                    compare_field("dio_level", want.dio_level, m_axis_tdata[1]);
                    compare_field("dio_released", want.dio_released, m_axis_tdata[2]);
                    compare_field("busy_res", want.busy_res, m_axis_tdata[3]);
                    compare_field("tdata padding", 4'h0, m_axis_tdata[7:4]);
                    compare_field("done_res", want.done_res, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_pins.push_back(advance_link(s_axis_tuser, s_axis_tdata[15:0],
                                                     s_axis_tdata[23:16]));
            pins_pending = expected_pins.size();
        end
    end

endmodule

### verif/four_digit_segment_serial_driver_core_tb.sv
`timescale 1ns / 1ps

module four_digit_segment_serial_driver_core_tb;
    import fdsd_pkg::*;

    // load to completing tick: start and data command, address command with
    // the segment bytes, then the brightness byte
    localparam int SEQ_TICKS    = 75 + 28 * (DIGIT_COUNT_DEF + 1);
    localparam int ITEM_TARGET  = 1650;
    localparam int LONG_HOLD    = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [15:0] number, [23:16] brightness
    logic        s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] clk_level, [1] dio_level,
                                 // [2] dio_released, [3] busy_res, [7:4] 0
    logic        m_axis_tlast;   // done_res

    int          link_faults;
    int          pins_pending;
    int          items_sent;
    int          quiet_cycles;
    int          holds_asked;
    int          holds_served;
    bit          steady_input;

    four_digit_segment_serial_driver_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    segment_link_checker link_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fault_count   (link_faults),
        .pins_pending  (pins_pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one item and return at the edge that takes it.
    task automatic send_item(input logic cmd, input logic [15:0] num, input logic [7:0] bri);
        int gap;
        gap = steady_input ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {bri, num};
        // ready is settled at the falling edge and holds until the next rising one
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // Load a number, then clock the link; stray loads land among the ticks.
    task automatic show_number(input logic [15:0] num, input logic [7:0] bri, input int ticks,
                               input int stray_at, input int stray_pct);
        send_item(CMD_LOAD, num, bri);
        for (int k = 0; k < ticks; k++)
        begin
            if (k == stray_at || $urandom_range(0, 99) < stray_pct)
                send_item(CMD_LOAD, 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)));
            send_item(CMD_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        while (pins_pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int          round;
        int          pick;
        logic [15:0] num;
        logic [7:0]  bri;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_TICK;
        items_sent    = 0;
        holds_asked   = 0;
        steady_input  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks while idle
        send_item(CMD_TICK, 16'hFFFF, 8'hFF);
        send_item(CMD_TICK, 16'h0000, 8'h00);
        // load while busy right after a load
        show_number(16'd0, 8'h00, SEQ_TICKS, 0, 0);
        // ten-thousands digit dropped; idle ticks after the completing tick
        show_number(16'hFFFF, 8'hFF, SEQ_TICKS + 2, 100, 0);
        show_number(16'd9999, 8'h8F, SEQ_TICKS, -1, 0);
        // stray load just before the completing tick
        show_number(16'd10000, 8'h88, SEQ_TICKS, SEQ_TICKS - 1, 0);
        show_number(16'd41234, 8'h01, SEQ_TICKS, -1, 0);
        show_number(16'd16780, 8'h80, SEQ_TICKS + 1, -1, 0);

        round = 0;
        while (items_sent < ITEM_TARGET)
        begin
            steady_input = ($urandom_range(0, 3) == 0);
            if (round == 0)
                holds_asked++;
            if (round == 1)
            begin
                s_axis_tvalid <= 1'b0;
                wait_results_drained();
            end
            // the first round runs a full sequence so the long hold sees traffic throughout
            pick = (round == 0) ? 99 : $urandom_range(0, 99);
            num  = $urandom_range(0, 1) ? 16'($urandom_range(0, 9999))
                                        : 16'($urandom_range(0, 65535));
            bri  = 8'($urandom_range(0, 255));
            if (pick < 10)
                repeat ($urandom_range(1, 6))
                    send_item(CMD_TICK, 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 255)));
            else if (pick < 22)
                show_number(num, bri, $urandom_range(1, SEQ_TICKS - 1), -1, 2);
            else
                show_number(num, bri, SEQ_TICKS + $urandom_range(0, 3), -1, 1);
            round++;
        end
        s_axis_tvalid <= 1'b0;

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (link_faults == 0 && pins_pending == 0)
            $display("four_digit_segment_serial_driver_core_tb passed");
        else
            $display("four_digit_segment_serial_driver_core_tb failed");
        $finish;
    end

    initial
    begin
        int span;
        m_axis_tready = 1'b0;
        holds_served  = 0;
        @(posedge rst_n);
        forever
        begin
            if (holds_served < holds_asked)
            begin
                // hold off long enough for the block to fill and stall its input
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b1;
                repeat (64) @(posedge clk);
            end
            else
            begin
                span = idle_gap();
                if (span > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("four_digit_segment_serial_driver_core_tb failed");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

endmodule

### sim.f
rtl/core/fdsd_pkg.sv
rtl/core/fdsd_digit_unit.sv
rtl/core/fdsd_out_buf.sv
rtl/core/four_digit_segment_serial_driver_core.sv
verif/segment_link_checker.sv
verif/four_digit_segment_serial_driver_core_tb.sv
